// ===== rtl/core/heading_moving_average_assert.svh =====
// assertion macros for the heading moving average block
`ifndef HEADING_MOVING_AVERAGE_ASSERT_SVH
`define HEADING_MOVING_AVERAGE_ASSERT_SVH

`ifndef SYNTH
`define HMA_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("heading_moving_average: assertion failed");
`define HMA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("heading_moving_average: assertion failed");
`else
`define HMA_ASSERT_HOLDS(lbl, cond)
`define HMA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/core/hma_pkg.sv =====
// shared types and constants for the heading moving average block
`timescale 1ns / 1ps
`default_nettype none

package hma_pkg;

    localparam int ANG_W     = 16;
    localparam int OUT_W     = 19;
    localparam int HALF_TURN = 32768;

    typedef logic [ANG_W-1:0]        t_angle;
    typedef logic signed [OUT_W-1:0] t_avg;

endpackage

`default_nettype wire

// ===== rtl/core/hma_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module hma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/heading_moving_average.sv =====
// heading moving average: unwrapped mean over a sliding window of headings
//
// input beat: i_heading_in, a 16-bit binary angle (65536 is one full turn),
// taken when i_in_valid and o_in_ready are both high. the sample replaces the
// oldest entry of a WINDOW_SIZE deep window held in a small ram.
// output beat: o_average_heading, 19-bit two's complement, the floor of the
// mean of the window unwrapped from its oldest sample, not rewrapped.
// one beat out for every beat in, in order.
// a sample is finished before the next one is taken: one ram read per
// window entry through a single unwrap adder, then one reciprocal multiply
// for the floor division, then the result is loaded into the output register.
// o_in_ready is high only while idle.
// the result sits in an output register, so the next sample is taken while
// a stalled result waits; the block holds its finished mean until that
// register is free.
// reset (synchronous, active low) clears the window valid bits so every
// entry reads as zero, and empties the output register. no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module heading_moving_average #(
    parameter int WINDOW_SIZE = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire hma_pkg::t_angle      i_heading_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output hma_pkg::t_avg             o_average_heading
);

`include "heading_moving_average_assert.svh"

    localparam int IDX_W   = $clog2(WINDOW_SIZE);
    localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
    localparam int ACC_W   = $clog2(WINDOW_SIZE) + 18;
    localparam int SUM_W   = ACC_W + $clog2(WINDOW_SIZE) + 1;
    localparam int SHIFT   = SUM_W + IDX_W;
    localparam int MUL_W   = SUM_W + 1;
    localparam int PROD_W  = SUM_W + MUL_W;
    localparam int QUO_W   = PROD_W - SHIFT;

    // ceiling of 2^SHIFT / WINDOW_SIZE, exact floor for every SUM_W-bit numerator
    localparam logic [63:0]      RECIP_FULL = ((64'd1 << SHIFT) + 64'(WINDOW_SIZE - 1))
                                              / 64'(WINDOW_SIZE);
    localparam logic [MUL_W-1:0] RECIP      = RECIP_FULL[MUL_W-1:0];

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]              r_state,    n_state;
    logic [WINDOW_SIZE-1:0]  r_vld,      n_vld;
    logic [IDX_W-1:0]        r_head,     n_head;
    logic [IDX_W-1:0]        r_rd_addr,  n_rd_addr;
    logic [CNT_W-1:0]        r_iss_cnt,  n_iss_cnt;
    logic [CNT_W-1:0]        r_proc_cnt, n_proc_cnt;
    logic                    r_rd_pend,  n_rd_pend;
    logic                    r_rd_vld,   n_rd_vld;
    hma_pkg::t_angle         r_prev,     n_prev;
    logic signed [ACC_W-1:0] r_acc,      n_acc;
    logic signed [SUM_W-1:0] r_sum,      n_sum;
    logic [SUM_W-1:0]        r_num,      n_num;
    logic [PROD_W-1:0]       r_prod,     n_prod;
    logic                    r_neg,      n_neg;
    logic                    r_out_vld,  n_out_vld;
    hma_pkg::t_avg           r_avg,      n_avg;

    logic                    in_acc;
    logic                    ram_we;
    hma_pkg::t_angle         ram_rdata;
    hma_pkg::t_angle         samp;
    logic signed [16:0]      diff;
    logic signed [16:0]      wdiff;
    logic signed [ACC_W-1:0] acc_step;
    logic [QUO_W-1:0]        quot_mag;
    logic [QUO_W-1:0]        quot;

    hma_ram #(
        .WIDTH (hma_pkg::ANG_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (i_heading_in),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready        = (r_state == ST_IDLE);
    assign in_acc            = i_in_valid && o_in_ready;
    assign ram_we            = in_acc;
    assign o_out_valid       = r_out_vld;
    assign o_average_heading = r_avg;

    // unwrap datapath
    assign samp     = r_rd_vld ? ram_rdata : '0;
    assign diff     = $signed({1'b0, samp}) - $signed({1'b0, r_prev});
    assign wdiff    = (diff == -17'(hma_pkg::HALF_TURN)) ? 17'(hma_pkg::HALF_TURN)
                                                          : {diff[15], diff[15:0]};
    assign acc_step = r_acc + ACC_W'(wdiff);

    // division datapath
    assign quot_mag = r_prod[PROD_W-1:SHIFT];
    assign quot     = r_neg ? (~quot_mag + QUO_W'(1)) : quot_mag;

    always_comb begin
        n_state    = r_state;
        n_vld      = r_vld;
        n_head     = r_head;
        n_rd_addr  = r_rd_addr;
        n_iss_cnt  = r_iss_cnt;
        n_proc_cnt = r_proc_cnt;
        n_rd_pend  = 1'b0;
        n_rd_vld   = r_rd_vld;
        n_prev     = r_prev;
        n_acc      = r_acc;
        n_sum      = r_sum;
        n_num      = r_num;
        n_prod     = r_prod;
        n_neg      = r_neg;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_avg      = r_avg;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_vld[r_head] = 1'b1;
                    n_head        = (r_head == IDX_W'(WINDOW_SIZE - 1)) ? '0 : r_head + 1'b1;
                    n_rd_addr     = n_head;
                    n_iss_cnt     = '0;
                    n_proc_cnt    = '0;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                if (r_iss_cnt != CNT_W'(WINDOW_SIZE)) begin
                    n_rd_pend = 1'b1;
                    n_rd_vld  = r_vld[r_rd_addr];
                    n_iss_cnt = r_iss_cnt + 1'b1;
                    n_rd_addr = (r_rd_addr == IDX_W'(WINDOW_SIZE - 1)) ? '0
                                                                        : r_rd_addr + 1'b1;
                end
                if (r_rd_pend) begin
                    n_prev     = samp;
                    n_proc_cnt = r_proc_cnt + 1'b1;
                    if (r_proc_cnt == '0) begin
                        n_acc = ACC_W'(samp);
                        n_sum = SUM_W'(samp);
                    end else begin
                        n_acc = acc_step;
                        n_sum = r_sum + SUM_W'(acc_step);
                    end
                    if (r_proc_cnt == CNT_W'(WINDOW_SIZE - 1)) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                // floor of a negative quotient is minus the ceiling of its magnitude
                n_neg     = r_sum[SUM_W-1];
                n_num     = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(WINDOW_SIZE))
                                           : r_sum;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                n_prod  = PROD_W'(r_num) * PROD_W'(RECIP);
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    n_avg     = quot[hma_pkg::OUT_W-1:0];
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_vld      <= '0;
            r_head     <= '0;
            r_rd_addr  <= '0;
            r_iss_cnt  <= '0;
            r_proc_cnt <= '0;
            r_rd_pend  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_vld      <= n_vld;
            r_head     <= n_head;
            r_rd_addr  <= n_rd_addr;
            r_iss_cnt  <= n_iss_cnt;
            r_proc_cnt <= n_proc_cnt;
            r_rd_pend  <= n_rd_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= n_rd_vld;
        r_prev   <= n_prev;
        r_acc    <= n_acc;
        r_sum    <= n_sum;
        r_num    <= n_num;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_avg    <= n_avg;
    end

    `HMA_ASSERT_NEXT(a_accept_starts_read, in_acc, (r_state == ST_READ) && (r_iss_cnt == '0))
    `HMA_ASSERT_HOLDS(a_proc_behind_issue, (r_state != ST_READ) || (r_proc_cnt <= r_iss_cnt))
    `HMA_ASSERT_NEXT(a_div_to_fin, (r_state == ST_DIV), (r_state == ST_FIN))
    `HMA_ASSERT_NEXT(a_fin_loads_free_reg, (r_state == ST_FIN) && !r_out_vld, r_out_vld && (r_state == ST_IDLE))

endmodule

`default_nettype wire
